// ===== rtl/rtip_pkg.sv =====
// ----------------------------------------------------------------------------
// rtip_pkg
// Shared types and constants of the radix integer text parser: base codes,
// register indexes, character constants and the records that move between
// the front end, the back end and the result queue.
// ----------------------------------------------------------------------------
package rtip_pkg;

  // Base codes, as held in the base_mode register
  typedef enum logic [1:0] {
    BASE_AUTO = 2'd0,
    BASE_OCT  = 2'd1,
    BASE_DEC  = 2'd2,
    BASE_HEX  = 2'd3
  } base_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_BASE_MODE  = 2'd0;
  localparam logic [1:0] CFG_MAX_DIGITS = 2'd1;
  localparam logic [1:0] CFG_NEGATE     = 2'd2;

  // Character constants
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_SEVEN = 8'd55;
  localparam logic [7:0] ASCII_NINE  = 8'd57;
  localparam logic [7:0] ASCII_UC_A  = 8'd65;
  localparam logic [7:0] ASCII_UC_F  = 8'd70;
  localparam logic [7:0] ASCII_LC_A  = 8'd97;
  localparam logic [7:0] ASCII_LC_F  = 8'd102;
  localparam logic [7:0] ASCII_LC_X  = 8'd120;
  localparam logic [7:0] HEX_UC_OFS  = 8'd55;
  localparam logic [7:0] HEX_LC_OFS  = 8'd87;

  localparam int unsigned ValueW     = 64;
  localparam int unsigned QueueDepth = 2;

  // Configuration as seen by the back end
  typedef struct packed {
    base_e       mode;
    logic [7:0]  max_digits;
    logic        negate;
  } cfg_t;

  // Classified character, front end to back end
  typedef struct packed {
    logic        start;
    logic        is_zero;
    logic        is_x;
    logic        oct_ok;
    logic        dec_ok;
    logic        hex_ok;
    logic [3:0]  dval;
  } class_t;

  // Result record; sign is applied at the result port
  typedef struct packed {
    logic              consumed;
    logic              done;
    logic [ValueW-1:0] acc;
  } res_t;

endpackage

// ===== rtl/rtip_queue.sv =====
// ----------------------------------------------------------------------------
// rtip_queue
// Small first-in first-out queue of registers. Head entry is shown while
// the queue is not empty; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module rtip_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/rtip_front.sv =====
// ----------------------------------------------------------------------------
// rtip_front
// Input side: takes one character beat per cycle unless its queue is full,
// classifies it against every base at once and queues it for the back end.
// ----------------------------------------------------------------------------
module rtip_front import rtip_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       start_req_i,
  input  logic [7:0] ch_i,
  input  logic       cls_pop_i,
  output class_t     cls_o,
  output logic       cls_empty_o
);

  class_t     cls;
  logic       is_dec, is_uc, is_lc;
  logic [7:0] ofs;
  logic [7:0] dsub;

  always_comb begin
    is_dec = (ch_i >= ASCII_ZERO) && (ch_i <= ASCII_NINE);
    is_uc  = (ch_i >= ASCII_UC_A) && (ch_i <= ASCII_UC_F);
    is_lc  = (ch_i >= ASCII_LC_A) && (ch_i <= ASCII_LC_F);
    priority if (is_uc) begin
      ofs = HEX_UC_OFS;
    end else if (is_lc) begin
      ofs = HEX_LC_OFS;
    end else begin
      ofs = ASCII_ZERO;
    end
    dsub = ch_i - ofs;

    cls.start   = start_req_i;
    cls.is_zero = (ch_i == ASCII_ZERO);
    cls.is_x    = (ch_i == ASCII_LC_X);
    cls.oct_ok  = (ch_i >= ASCII_ZERO) && (ch_i <= ASCII_SEVEN);
    cls.dec_ok  = is_dec;
    cls.hex_ok  = is_dec || is_uc || is_lc;
    cls.dval    = dsub[3:0];
  end

  rtip_queue #(
    .Width ($bits(class_t)),
    .Depth (Depth)
  ) u_cls_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cls),
    .full_o  (full),
    .pop_i   (cls_pop_i),
    .data_o  (cls_o),
    .empty_o (cls_empty_o)
  );

endmodule

// ===== rtl/rtip_back.sv =====
// ----------------------------------------------------------------------------
// rtip_back
// Parse engine: pops one classified character per cycle unless stalled, tracks
// prefix, base and digit limit, and accumulates the value modulo 2^64.
// ----------------------------------------------------------------------------
module rtip_back import rtip_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  class_t cls_i,
  input  logic   cls_empty_i,
  output logic   cls_pop_o,
  output res_t   res_o,
  output logic   res_push_o,
  input  logic   res_full_i
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEAD_ZERO,
    PH_DIGITS
  } phase_e;

  phase_e            phase_q, phase_d;
  base_e             base_q, base_d;
  logic [7:0]        left_q, left_d;
  logic [ValueW-1:0] acc_q, acc_d;

  logic              step;
  logic              take_en;
  base_e             tb;
  logic [7:0]        tl;
  logic [ValueW-1:0] ta;
  logic [ValueW-1:0] scaled;
  logic              dig_ok;
  logic              cons, done;

  assign step       = !cls_empty_i && !res_full_i;
  assign cls_pop_o  = step;
  assign res_push_o = step;

  always_comb begin
    phase_d = phase_q;
    base_d  = base_q;
    left_d  = left_q;
    acc_d   = acc_q;
    cons    = 1'b0;
    done    = 1'b0;
    take_en = 1'b0;
    tb      = base_q;
    tl      = left_q;
    ta      = acc_q;

    priority if (cls_i.start) begin
      acc_d  = '0;
      left_d = cfg_i.max_digits;
      if (cls_i.is_zero && (cfg_i.mode == BASE_AUTO || cfg_i.mode == BASE_HEX)) begin
        base_d  = cfg_i.mode;
        phase_d = PH_LEAD_ZERO;
        cons    = 1'b1;
      end else begin
        take_en = 1'b1;
        tb      = (cfg_i.mode == BASE_AUTO) ? BASE_DEC : cfg_i.mode;
        tl      = cfg_i.max_digits;
        ta      = '0;
        base_d  = tb;
      end
    end else if (phase_q == PH_LEAD_ZERO) begin
      if (cls_i.is_x) begin
        base_d  = BASE_HEX;
        phase_d = PH_DIGITS;
        cons    = 1'b1;
      end else begin
        // the held zero counts as a digit now
        tb     = (base_q == BASE_AUTO) ? BASE_OCT : base_q;
        base_d = tb;
        if (left_q == 8'd1) begin
          left_d  = '0;
          phase_d = PH_IDLE;
          done    = 1'b1;
        end else begin
          take_en = 1'b1;
          tl      = (left_q != '0) ? left_q - 8'd1 : '0;
        end
      end
    end else if (phase_q == PH_DIGITS) begin
      take_en = 1'b1;
    end else begin
      phase_d = PH_IDLE;
    end

    unique case (tb)
      BASE_OCT: dig_ok = cls_i.oct_ok;
      BASE_HEX: dig_ok = cls_i.hex_ok;
      default:  dig_ok = cls_i.dec_ok;
    endcase

    unique case (tb)
      BASE_OCT: scaled = ta << 3;
      BASE_HEX: scaled = ta << 4;
      default:  scaled = (ta << 3) + (ta << 1);
    endcase

    if (take_en) begin
      left_d = tl;
      if (!dig_ok) begin
        phase_d = PH_IDLE;
        done    = 1'b1;
      end else begin
        acc_d   = scaled + ValueW'(cls_i.dval);
        cons    = 1'b1;
        phase_d = PH_DIGITS;
        if (tl != '0) begin
          left_d = tl - 8'd1;
          if (tl == 8'd1) begin
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
        end
      end
    end

    res_o.consumed = cons;
    res_o.done     = done;
    res_o.acc      = acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      base_q  <= BASE_AUTO;
      left_q  <= '0;
      acc_q   <= '0;
    end else if (step) begin
      phase_q <= phase_d;
      base_q  <= base_d;
      left_q  <= left_d;
      acc_q   <= acc_d;
    end
  end

endmodule

// ===== rtl/radix_integer_text_parser.sv =====
// ----------------------------------------------------------------------------
// radix_integer_text_parser
// Streaming parser of one unsigned integer in base 8, 10 or 16 (or detected
// from a "0x" / "0" prefix), one character per beat, with digit limit and
// optional negation of the result.
// ----------------------------------------------------------------------------
//   channel   handshake               payload
//   input     push / full             start_req_i, ch_i
//   result    empty / pop             consumed_o, done_res_o, value_o
//   config    cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One beat per cycle in both directions while no queue is full; one result
// per beat. Beats pass the classification queue, then the parse engine whose
// shift-add accumulate writes the result queue.
// Reset clears queue pointers, the parse state and the config; empty is high.
// A full result queue stalls the engine; the input side keeps taking beats
// until its own queue fills.
// ----------------------------------------------------------------------------
module radix_integer_text_parser import rtip_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               start_req_i,
  input  logic [7:0]         ch_i,
  output logic               empty,
  input  logic               pop,
  output logic               consumed_o,
  output logic               done_res_o,
  output logic signed [63:0] value_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  cfg_t   cfg_q;
  class_t cls;
  logic   cls_empty, cls_pop;
  res_t   res_in, res_out;
  logic   res_push, res_full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode       <= BASE_AUTO;
      cfg_q.max_digits <= '0;
      cfg_q.negate     <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_BASE_MODE:  cfg_q.mode       <= base_e'(cfg_data_i[1:0]);
        CFG_MAX_DIGITS: cfg_q.max_digits <= cfg_data_i;
        CFG_NEGATE:     cfg_q.negate     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  rtip_front #(
    .Depth (Depth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .start_req_i (start_req_i),
    .ch_i        (ch_i),
    .cls_pop_i   (cls_pop),
    .cls_o       (cls),
    .cls_empty_o (cls_empty)
  );

  rtip_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cls_i       (cls),
    .cls_empty_i (cls_empty),
    .cls_pop_o   (cls_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  rtip_queue #(
    .Width ($bits(res_t)),
    .Depth (Depth)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  // apply sign on the way out
  assign consumed_o = res_out.consumed;
  assign done_res_o = res_out.done;
  assign value_o    = $signed(cfg_q.negate ? (64'd0 - res_out.acc) : res_out.acc);

endmodule

// ===== rtl/rtip_checker.sv =====
// ----------------------------------------------------------------------------
// rtip_checker
// Port-level checks: result queue empty after reset, no result while no beat
// is outstanding, input full only with beats in flight, held result on stall.
// ----------------------------------------------------------------------------
module rtip_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic               consumed_o,
  input logic               done_res_o,
  input logic signed [63:0] value_o
);

  logic [15:0] pend_q, pend_d;
  logic        acc_in, acc_out;

  assign acc_in  = push && !full;
  assign acc_out = pop && !empty;

  always_comb begin
    pend_d = pend_q;
    if (acc_in && !acc_out) begin
      pend_d = pend_q + 16'd1;
    end else if (acc_out && !acc_in) begin
      pend_d = pend_q - 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_reset_empty : assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result queue not empty after reset");

  a_no_invented : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == 16'd0) |-> empty)
    else $error("result shown with no beat outstanding");

  a_full_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> (pend_q != 16'd0))
    else $error("input full with nothing in flight");

  a_hold_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(consumed_o) && $stable(done_res_o)
                          && $stable(value_o)))
    else $error("stalled result changed");

endmodule

bind radix_integer_text_parser rtip_checker u_rtip_checker (.*);
